// ===== rtl/core/stable_priority_queue_with_history_assert.svh =====
// Assertion macros used by the checker of the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_WITH_HISTORY_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_WITH_HISTORY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define SPQH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define SPQH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spqh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spqh_pkg;

    localparam int ID_W     = 16;
    localparam int PRIO_W   = 3;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_POP = 2'd2,
        OP_NOP = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_QEMPTY = 2'd1,
        ST_QFULL  = 2'd2,
        ST_HEMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Shared command for every queue cell in one cycle.
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } q_ctrl_t;

    // Shared command for every history cell in one cycle.
    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] new_id;
    } h_ctrl_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic               dropped;
        logic [COUNT_W-1:0] qcount;
        logic [COUNT_W-1:0] hcount;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/stable_priority_queue_with_history.sv =====
// Stable priority queue with a last-in-first-out history of dequeued ids.
// Each accepted item is one operation: enqueue (id and priority), dequeue
// of the highest-priority entry, or pop of the newest history id. Entries of
// equal priority leave in arrival order. The block takes one item every clock
// cycle while in_ready is high: every queue cell compares its own priority
// with the new one and looks only at its two neighbors, so an insert or a
// removal finishes in the cycle the item is accepted, and the result is
// presented from an output register. A second output register lets one
// more item in while a result is waiting; with both full, in_ready drops.
// Queue and history contents are held in the cells without reset; the fill
// counters decide which cells are live.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_with_history #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        opcode,
    input  wire logic [spqh_pkg::ID_W-1:0]         item_id,
    input  wire logic [spqh_pkg::PRIO_W-1:0]       priority_req,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [spqh_pkg::STATUS_W-1:0]          status,
    output logic [spqh_pkg::ID_W-1:0]              out_id,
    output logic [spqh_pkg::PRIO_W-1:0]            out_priority,
    output logic                                   history_dropped,
    output logic [spqh_pkg::COUNT_W-1:0]           queue_count,
    output logic [spqh_pkg::COUNT_W-1:0]           history_count
);

    // Fill counters are wide enough to hold the full depth.
    localparam int QFW = $clog2(QUEUE_DEPTH + 1);
    localparam int HFW = $clog2(HISTORY_DEPTH + 1);

    logic [QFW-1:0] q_fill_reg;
    logic [QFW-1:0] q_fill_next;
    logic [HFW-1:0] h_fill_reg;
    logic [HFW-1:0] h_fill_next;

    // Output buffer: the main register drives the ports, the skid register
    // catches one result while the main one is stalled.
    spqh_pkg::result_t out_res_reg;
    spqh_pkg::result_t skid_res_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    spqh_pkg::q_ctrl_t q_ctrl;
    spqh_pkg::h_ctrl_t h_ctrl;
    spqh_pkg::result_t res;

    spqh_pkg::entry_t          q_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    q_keep;
    logic [spqh_pkg::ID_W-1:0] h_id    [HISTORY_DEPTH];

    logic acc;
    logic out_take;
    logic q_full;
    logic q_empty;
    logic h_full;
    logic h_empty;

    assign in_ready = !skid_valid_reg;
    assign acc      = in_valid && in_ready;
    assign out_take = !out_valid_reg || out_ready;

    assign q_full  = (q_fill_reg == QFW'(QUEUE_DEPTH));
    assign q_empty = (q_fill_reg == '0);
    assign h_full  = (h_fill_reg == HFW'(HISTORY_DEPTH));
    assign h_empty = (h_fill_reg == '0);

    // Decode the operation. Cell commands are only raised for an accepted
    // item that actually changes the queue or the history.
    always_comb
    begin
        q_ctrl.enq                = 1'b0;
        q_ctrl.deq                = 1'b0;
        q_ctrl.new_entry.id       = item_id;
        q_ctrl.new_entry.prio     = priority_req;
        h_ctrl.push               = 1'b0;
        h_ctrl.pop                = 1'b0;
        h_ctrl.new_id             = q_entry[0].id;
        q_fill_next               = q_fill_reg;
        h_fill_next               = h_fill_reg;
        res.status                = spqh_pkg::ST_OK;
        res.id                    = '0;
        res.prio                  = '0;
        res.dropped               = 1'b0;

        if (acc)
        begin
            unique case (spqh_pkg::opcode_t'(opcode))
                spqh_pkg::OP_ENQ:
                begin
                    if (q_full)
                    begin
                        res.status = spqh_pkg::ST_QFULL;
                    end
                    else
                    begin
                        q_ctrl.enq  = 1'b1;
                        q_fill_next = q_fill_reg + 1'b1;
                    end
                end
                spqh_pkg::OP_DEQ:
                begin
                    if (q_empty)
                    begin
                        res.status = spqh_pkg::ST_QEMPTY;
                    end
                    else
                    begin
                        q_ctrl.deq  = 1'b1;
                        q_fill_next = q_fill_reg - 1'b1;
                        res.id      = q_entry[0].id;
                        res.prio    = q_entry[0].prio;
                        // A full history keeps its contents and the id is lost.
                        if (h_full)
                        begin
                            res.dropped = 1'b1;
                        end
                        else
                        begin
                            h_ctrl.push = 1'b1;
                            h_fill_next = h_fill_reg + 1'b1;
                        end
                    end
                end
                spqh_pkg::OP_POP:
                begin
                    if (h_empty)
                    begin
                        res.status = spqh_pkg::ST_HEMPTY;
                    end
                    else
                    begin
                        h_ctrl.pop  = 1'b1;
                        h_fill_next = h_fill_reg - 1'b1;
                        res.id      = h_id[0];
                    end
                end
                default:
                begin
                    // The unused code is a no-operation that still returns a result.
                end
            endcase
        end

        res.qcount = spqh_pkg::COUNT_W'(q_fill_next);
        res.hcount = spqh_pkg::COUNT_W'(h_fill_next);
    end

    // Queue chain. The first cell sees an always-keeping boundary on its
    // left, so it takes the new entry whenever it does not keep its own entry.
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_qcell
        logic             left_keep;
        spqh_pkg::entry_t left_entry;
        spqh_pkg::entry_t right_entry;

        if (k == 0)
        begin : g_first
            assign left_keep  = 1'b1;
            assign left_entry = q_ctrl.new_entry;
        end
        else
        begin : g_mid
            assign left_keep  = q_keep[k-1];
            assign left_entry = q_entry[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = q_ctrl.new_entry;
        end
        else
        begin : g_inner
            assign right_entry = q_entry[k+1];
        end

        spqh_qcell u_qcell (
            .clk         (clk),
            .ctrl        (q_ctrl),
            .occupied    (q_fill_reg > QFW'(k)),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .keep        (q_keep[k]),
            .entry       (q_entry[k])
        );
    end

    // History chain, newest id in the first cell.
    for (genvar k = 0; k < HISTORY_DEPTH; k++)
    begin : g_hcell
        logic [spqh_pkg::ID_W-1:0] left_id;
        logic [spqh_pkg::ID_W-1:0] right_id;

        if (k == 0)
        begin : g_first
            assign left_id = h_ctrl.new_id;
        end
        else
        begin : g_mid
            assign left_id = h_id[k-1];
        end

        if (k == HISTORY_DEPTH - 1)
        begin : g_last
            assign right_id = h_ctrl.new_id;
        end
        else
        begin : g_inner
            assign right_id = h_id[k+1];
        end

        spqh_hcell u_hcell (
            .clk      (clk),
            .ctrl     (h_ctrl),
            .left_id  (left_id),
            .right_id (right_id),
            .id       (h_id[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_fill_reg <= '0;
            h_fill_reg <= '0;
        end
        else
        begin
            q_fill_reg <= q_fill_next;
            h_fill_reg <= h_fill_next;
        end
    end

    // Output buffer control. The skid register is only filled while the
    // main register holds a stalled result, and drains into it first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= acc;
            end
        end
        else if (acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : res;
        end
        else if (acc)
        begin
            skid_res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_res_reg.status;
    assign out_id          = out_res_reg.id;
    assign out_priority    = out_res_reg.prio;
    assign history_dropped = out_res_reg.dropped;
    assign queue_count     = out_res_reg.qcount;
    assign history_count   = out_res_reg.hcount;

endmodule

`default_nettype wire

// ===== rtl/core/spqh_qcell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted queue. The cell keeps its entry when it outranks
// or ties the new one, takes the new entry at the insert boundary, and
// otherwise takes its left neighbor's entry. On dequeue it takes the right one.
module spqh_qcell (
    input  wire logic              clk,
    input  wire spqh_pkg::q_ctrl_t ctrl,
    input  wire logic              occupied,
    input  wire logic              left_keep,
    input  wire spqh_pkg::entry_t  left_entry,
    input  wire spqh_pkg::entry_t  right_entry,
    output logic                   keep,
    output spqh_pkg::entry_t       entry
);

    spqh_pkg::entry_t entry_reg;
    spqh_pkg::entry_t entry_next;

    assign keep  = occupied && (entry_reg.prio >= ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? ctrl.new_entry : left_entry;
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/spqh_hcell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One slot of the history stack. The newest id sits in the first cell;
// a push moves every id one cell down and a pop moves every id one cell up.
module spqh_hcell (
    input  wire logic                          clk,
    input  wire spqh_pkg::h_ctrl_t             ctrl,
    input  wire logic [spqh_pkg::ID_W-1:0]     left_id,
    input  wire logic [spqh_pkg::ID_W-1:0]     right_id,
    output logic [spqh_pkg::ID_W-1:0]          id
);

    logic [spqh_pkg::ID_W-1:0] id_reg;
    logic [spqh_pkg::ID_W-1:0] id_next;

    assign id = id_reg;

    always_comb
    begin
        id_next = id_reg;
        if (ctrl.push)
        begin
            id_next = left_id;
        end
        else if (ctrl.pop)
        begin
            id_next = right_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/spqh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "stable_priority_queue_with_history_assert.svh"

// Port-level checks on the priority queue.
module spqh_checker #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int HISTORY_DEPTH = 16
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic [1:0]                  opcode,
    input wire logic [spqh_pkg::ID_W-1:0]   item_id,
    input wire logic [spqh_pkg::PRIO_W-1:0] priority_req,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [spqh_pkg::STATUS_W-1:0] status,
    input wire logic [spqh_pkg::ID_W-1:0]   out_id,
    input wire logic [spqh_pkg::PRIO_W-1:0] out_priority,
    input wire logic                        history_dropped,
    input wire logic [spqh_pkg::COUNT_W-1:0] queue_count,
    input wire logic [spqh_pkg::COUNT_W-1:0] history_count
);

    logic unused_in;

    assign unused_in = in_valid ^ (^opcode) ^ (^item_id) ^ (^priority_req);

    `SPQH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_id) && $stable(status) && $stable(queue_count),
        "stalled result changed")

    `SPQH_ASSERT_NOW(a_backpressure, !in_ready, out_valid,
        "input stalled with no result waiting")

    `SPQH_ASSERT_NOW(a_qempty, out_valid && status == spqh_pkg::ST_QEMPTY,
        out_id == '0 && out_priority == '0 && queue_count == '0,
        "queue empty result not clean")

    `SPQH_ASSERT_NOW(a_hempty, out_valid && status == spqh_pkg::ST_HEMPTY,
        out_id == '0 && history_count == '0 && !history_dropped,
        "history empty result not clean")

    `SPQH_ASSERT_NOW(a_dropped, out_valid && history_dropped,
        status == spqh_pkg::ST_OK
            && history_count == spqh_pkg::COUNT_W'(HISTORY_DEPTH),
        "history drop without full history")

endmodule

bind stable_priority_queue_with_history spqh_checker #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
) u_spqh_checker (.*);

`default_nettype wire
